>>> rtl/core/wrfd_pkg.sv
// ----------------------------------------------------------------------------
// wrfd_pkg
// Shared types, register map, reset values and the arctangent table of the
// wrist roll flick detector.
// ----------------------------------------------------------------------------
package wrfd_pkg;

	localparam int SAMPLE_BITS_DEF = 13;
	localparam int ATAN_ITER_DEF   = 12;

	localparam int LIMIT_W   = 14;
	localparam int ANGLE_W   = 8;
	localparam int SETTLE_W  = 2;
	localparam int ROLL_W    = 9;
	localparam int DIFF_W    = 10;
	localparam int ACC_W     = 27;
	localparam int FRAC_W    = 16;
	localparam int ATAN_W    = 22;
	localparam int ATAN_IDX_W = 4;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_SHAKE_LIMIT  = 3'd0;
	localparam logic [2:0] REG_GRAVITY_LOW  = 3'd1;
	localparam logic [2:0] REG_GRAVITY_HIGH = 3'd2;
	localparam logic [2:0] REG_DEAD_ZONE    = 3'd3;
	localparam logic [2:0] REG_FLICK_THR    = 3'd4;
	localparam logic [2:0] REG_COOLDOWN     = 3'd5;
	localparam logic [2:0] REG_SETTLE       = 3'd6;

	localparam logic [LIMIT_W-1:0]  SHAKE_LIMIT_RST  = 14'd5000;
	localparam logic [LIMIT_W-1:0]  GRAVITY_LOW_RST  = 14'd1000;
	localparam logic [LIMIT_W-1:0]  GRAVITY_HIGH_RST = 14'd1700;
	localparam logic [ANGLE_W-1:0]  DEAD_ZONE_RST    = 8'd70;
	localparam logic [ANGLE_W-1:0]  FLICK_THR_RST    = 8'd70;
	localparam logic [ANGLE_W-1:0]  COOLDOWN_RST     = 8'd10;
	localparam logic [SETTLE_W-1:0] SETTLE_RST       = 2'd3;

	localparam int HALF_TURN = 180;
	localparam int FULL_TURN = 360;

	typedef enum logic [1:0] {
		EVT_NONE  = 2'd0,
		EVT_UP    = 2'd1,
		EVT_DOWN  = 2'd2,
		EVT_SHAKE = 2'd3
	} gesture_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  shake_limit;
		logic [LIMIT_W-1:0]  gravity_low;
		logic [LIMIT_W-1:0]  gravity_high;
		logic [ANGLE_W-1:0]  roll_dead_zone;
		logic [ANGLE_W-1:0]  flick_threshold;
		logic [ANGLE_W-1:0]  cooldown_samples;
		logic [SETTLE_W-1:0] settle_samples;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic rot_step;
		logic roll;
		logic decide;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic early;
	} stat_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			4'd0:  r = 22'd2949120;
			4'd1:  r = 22'd1740967;
			4'd2:  r = 22'd919879;
			4'd3:  r = 22'd466945;
			4'd4:  r = 22'd234379;
			4'd5:  r = 22'd117304;
			4'd6:  r = 22'd58666;
			4'd7:  r = 22'd29335;
			4'd8:  r = 22'd14668;
			4'd9:  r = 22'd7334;
			4'd10: r = 22'd3667;
			4'd11: r = 22'd1833;
			4'd12: r = 22'd917;
			4'd13: r = 22'd458;
			4'd14: r = 22'd229;
			4'd15: r = 22'd115;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/wrfd_in_if.sv
// ----------------------------------------------------------------------------
// wrfd_in_if
// Sample channel: valid/ready handshake with one accelerometer sample per beat.
// ----------------------------------------------------------------------------
interface wrfd_in_if #(
	parameter int SAMPLE_BITS = 13
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;
	logic                          motor_active;

	modport source (output valid, accel_x, accel_y, accel_z, motor_active, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, motor_active, output ready);
endinterface

>>> rtl/core/wrfd_out_if.sv
// ----------------------------------------------------------------------------
// wrfd_out_if
// Event channel: valid/ready handshake with one gesture event per beat.
// ----------------------------------------------------------------------------
interface wrfd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] gesture_event;

	modport source (output valid, gesture_event, input ready);
	modport sink   (input valid, gesture_event, output ready);
endinterface

>>> rtl/core/wrfd_regs.sv
// ----------------------------------------------------------------------------
// wrfd_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
module wrfd_regs
	import wrfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shake_limit      <= SHAKE_LIMIT_RST;
			cfg_q.gravity_low      <= GRAVITY_LOW_RST;
			cfg_q.gravity_high     <= GRAVITY_HIGH_RST;
			cfg_q.roll_dead_zone   <= DEAD_ZONE_RST;
			cfg_q.flick_threshold  <= FLICK_THR_RST;
			cfg_q.cooldown_samples <= COOLDOWN_RST;
			cfg_q.settle_samples   <= SETTLE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SHAKE_LIMIT:  cfg_q.shake_limit      <= pwdata[LIMIT_W-1:0];
				REG_GRAVITY_LOW:  cfg_q.gravity_low      <= pwdata[LIMIT_W-1:0];
				REG_GRAVITY_HIGH: cfg_q.gravity_high     <= pwdata[LIMIT_W-1:0];
				REG_DEAD_ZONE:    cfg_q.roll_dead_zone   <= pwdata[ANGLE_W-1:0];
				REG_FLICK_THR:    cfg_q.flick_threshold  <= pwdata[ANGLE_W-1:0];
				REG_COOLDOWN:     cfg_q.cooldown_samples <= pwdata[ANGLE_W-1:0];
				REG_SETTLE:       cfg_q.settle_samples   <= pwdata[SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_SHAKE_LIMIT:  prdata = PDATA_W'(cfg_q.shake_limit);
			REG_GRAVITY_LOW:  prdata = PDATA_W'(cfg_q.gravity_low);
			REG_GRAVITY_HIGH: prdata = PDATA_W'(cfg_q.gravity_high);
			REG_DEAD_ZONE:    prdata = PDATA_W'(cfg_q.roll_dead_zone);
			REG_FLICK_THR:    prdata = PDATA_W'(cfg_q.flick_threshold);
			REG_COOLDOWN:     prdata = PDATA_W'(cfg_q.cooldown_samples);
			REG_SETTLE:       prdata = PDATA_W'(cfg_q.settle_samples);
			default:          prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/wrfd_ctrl.sv
// ----------------------------------------------------------------------------
// wrfd_ctrl
// Sequencer: capture, screen, CORDIC iterations, roll, decision, output load.
// ----------------------------------------------------------------------------
module wrfd_ctrl
	import wrfd_pkg::*;
#(
	parameter int ATAN_ITERATIONS = ATAN_ITER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  stat_t                 stat,
	output cmd_t                  cmd,
	output logic [ATAN_IDX_W-1:0] iter
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ROT,
		S_ROLL,
		S_DECIDE,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [ATAN_IDX_W-1:0] iter_q;
	logic                  out_valid_q;
	logic                  slot_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign iter      = iter_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.eval     = (state_q == S_EVAL);
		cmd.rot_step = (state_q == S_ROT);
		cmd.roll     = (state_q == S_ROLL);
		cmd.decide   = (state_q == S_DECIDE);
		cmd.load_out = (state_q == S_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one leaving in the same cycle
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					iter_q  <= '0;
					state_q <= stat.early ? S_DONE : S_ROT;
				end
				S_ROT: begin
					if (iter_q == ATAN_IDX_W'(ATAN_ITERATIONS - 1)) begin
						state_q <= S_ROLL;
					end
					iter_q <= iter_q + 1'b1;
				end
				S_ROLL: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/wrfd_datapath.sv
// ----------------------------------------------------------------------------
// wrfd_datapath
// Sample registers, L1 screen, shared CORDIC stage, roll and gesture state.
// ----------------------------------------------------------------------------
module wrfd_datapath
	import wrfd_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  cmd_t                          cmd,
	input  logic [ATAN_IDX_W-1:0]         iter,
	output stat_t                         stat,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	input  logic                          motor_active,
	output logic [1:0]                    gesture_event
);

	localparam int SUM_W = SAMPLE_BITS + 2;
	localparam int CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;
	localparam int V_W   = SAMPLE_BITS + 10;
	localparam int DEG_W = ACC_W - FRAC_W;

	// captured sample
	logic signed [SAMPLE_BITS-1:0] x_q, y_q, z_q;
	logic                          motor_q;

	// CORDIC state
	logic signed [V_W-1:0]   vx_q, vy_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    zero_q;
	logic signed [ROLL_W-1:0] roll_q;

	// gesture state
	logic signed [ROLL_W-1:0] ref_roll_q;
	logic                     need_ref_q;
	logic [SETTLE_W-1:0]      settle_q;
	logic [ANGLE_W-1:0]       cool_q;
	gesture_t                 evt_q;
	gesture_t                 out_q;

	// screen
	logic signed [SUM_W-1:0] xe, ye, ze;
	logic [SUM_W-1:0]        l1_sum;
	logic [CMP_W-1:0]        sum_c, shake_c, glow_c, ghigh_c;
	logic                    is_shake, out_window;

	always_comb begin
		xe = SUM_W'(x_q);
		ye = SUM_W'(y_q);
		ze = SUM_W'(z_q);
		l1_sum = (xe < 0 ? -xe : xe) + (ye < 0 ? -ye : ye) + (ze < 0 ? -ze : ze);
		sum_c   = CMP_W'(l1_sum);
		shake_c = CMP_W'(cfg.shake_limit);
		glow_c  = CMP_W'(cfg.gravity_low);
		ghigh_c = CMP_W'(cfg.gravity_high);
		is_shake   = sum_c > shake_c;
		out_window = (sum_c < glow_c) || (sum_c > ghigh_c);
		stat.early = (cool_q != '0) || motor_q || is_shake || out_window;
	end

	// CORDIC start vector, left half plane folded by 180 degrees
	logic signed [V_W-1:0]   vz0, vy0;
	logic signed [ACC_W-1:0] half_turn_q16;

	assign vz0 = $signed({{(V_W-SAMPLE_BITS-8){z_q[SAMPLE_BITS-1]}}, z_q, 8'b0});
	assign vy0 = $signed({{(V_W-SAMPLE_BITS-8){y_q[SAMPLE_BITS-1]}}, y_q, 8'b0});
	assign half_turn_q16 = ACC_W'(HALF_TURN) <<< FRAC_W;

	// one micro-rotation
	logic signed [V_W-1:0]   sh_x, sh_y;
	logic signed [ACC_W-1:0] atan_step;

	always_comb begin
		sh_x      = vx_q >>> iter;
		sh_y      = vy_q >>> iter;
		atan_step = ACC_W'(atan_q16(iter));
	end

	// truncate toward zero, clamp to a half turn
	logic [ACC_W-1:0]         acc_abs;
	logic [DEG_W-1:0]         deg_mag;
	logic [ROLL_W-1:0]        deg_clamp;
	logic signed [ROLL_W-1:0] roll_next;

	always_comb begin
		acc_abs   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		deg_mag   = acc_abs[ACC_W-1:FRAC_W];
		deg_clamp = (deg_mag > DEG_W'(HALF_TURN)) ? ROLL_W'(HALF_TURN) : ROLL_W'(deg_mag);
		if (zero_q) begin
			roll_next = '0;
		end else begin
			roll_next = acc_q[ACC_W-1] ? -$signed(deg_clamp) : $signed(deg_clamp);
		end
	end

	// decision
	logic [ANGLE_W-1:0]       rmag;
	logic signed [DIFF_W-1:0] diff_raw, diff;
	logic [ANGLE_W-1:0]       dmag;
	logic                     in_dead, flick;

	always_comb begin
		rmag     = roll_q[ROLL_W-1] ? ANGLE_W'(-roll_q) : ANGLE_W'(roll_q);
		in_dead  = (roll_q != '0) && (rmag < cfg.roll_dead_zone);
		diff_raw = DIFF_W'(roll_q) - DIFF_W'(ref_roll_q);
		diff     = diff_raw;
		if (diff_raw < -DIFF_W'(HALF_TURN)) begin
			diff = diff_raw + DIFF_W'(FULL_TURN);
		end else if (diff_raw > DIFF_W'(HALF_TURN)) begin
			diff = diff_raw - DIFF_W'(FULL_TURN);
		end
		dmag  = diff[DIFF_W-1] ? ANGLE_W'(-diff) : ANGLE_W'(diff);
		flick = dmag > cfg.flick_threshold;
	end

	assign gesture_event = out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q     <= accel_x;
			y_q     <= accel_y;
			z_q     <= accel_z;
			motor_q <= motor_active;
		end
		if (cmd.eval) begin
			zero_q <= (y_q == '0) && (z_q == '0);
			if (vz0 < 0) begin
				vx_q  <= -vz0;
				vy_q  <= -vy0;
				acc_q <= y_q[SAMPLE_BITS-1] ? -half_turn_q16 : half_turn_q16;
			end else begin
				vx_q  <= vz0;
				vy_q  <= vy0;
				acc_q <= '0;
			end
		end
		if (cmd.rot_step) begin
			if (vy_q >= 0) begin
				vx_q  <= vx_q + sh_y;
				vy_q  <= vy_q - sh_x;
				acc_q <= acc_q + atan_step;
			end else begin
				vx_q  <= vx_q - sh_y;
				vy_q  <= vy_q + sh_x;
				acc_q <= acc_q - atan_step;
			end
		end
		if (cmd.roll) begin
			roll_q <= roll_next;
		end
		if (cmd.load_out) begin
			out_q <= evt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_roll_q <= '0;
			need_ref_q <= 1'b1;
			settle_q   <= '0;
			cool_q     <= '0;
			evt_q      <= EVT_NONE;
		end else begin
			if (cmd.eval) begin
				evt_q <= EVT_NONE;
				if (cool_q != '0) begin
					cool_q <= cool_q - 1'b1;
				end else if (!motor_q && is_shake) begin
					cool_q     <= cfg.cooldown_samples;
					need_ref_q <= 1'b1;
					settle_q   <= '0;
					evt_q      <= EVT_SHAKE;
				end
			end
			if (cmd.decide && !in_dead) begin
				if (need_ref_q) begin
					need_ref_q <= 1'b0;
					ref_roll_q <= roll_q;
				end else if (settle_q == '0) begin
					if (flick) begin
						settle_q <= (cfg.settle_samples != '0) ? cfg.settle_samples
						                                       : SETTLE_W'(1);
					end else begin
						ref_roll_q <= roll_q;
					end
				end else if (settle_q == SETTLE_W'(1)) begin
					settle_q <= '0;
					if (flick) begin
						evt_q      <= (diff > 0) ? EVT_DOWN : EVT_UP;
						cool_q     <= cfg.cooldown_samples;
						need_ref_q <= 1'b1;
					end else begin
						ref_roll_q <= roll_q;
					end
				end else begin
					settle_q <= settle_q - 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/core/wrist_roll_flick_detector_unit.sv
// ----------------------------------------------------------------------------
// wrist_roll_flick_detector_unit
// Wrist roll flick detector: one accelerometer sample in, one gesture out.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch (sink) takes one sample beat: accel_x/y/z and motor_active.
//  - out_ch (source) gives one gesture_event beat per sample, in order:
//    0 none, 1 scroll up, 2 scroll down, 3 shake.
//  - APB port sets the seven thresholds at byte address 4*index; write only
//    while no sample is in flight. pready is tied high.
// Sequencing:
//  - Samples rejected by cooldown, motor, shake or gravity window skip the
//    CORDIC: the sequencer goes from EVAL straight to DONE.
//  - Samples that need a roll angle: EVAL, ROT (the single CORDIC stage, reused
//    once per iteration for ATAN_ITERATIONS, default 12), ROLL, DECIDE, DONE.
//  - One sample in flight at a time; the next one can be taken in the cycle
//    after the previous result is loaded into the output register.
// Reset: registers go to their reset values, reference is re-learned, no
//  settling or cooldown pending, out_ch empty.
// Stall: a held result sits in the output register while the next sample is
//  processed; that sample then waits in its last state until the slot frees.
// ----------------------------------------------------------------------------
module wrist_roll_flick_detector_unit
	import wrfd_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int ATAN_ITERATIONS = ATAN_ITER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	wrfd_in_if.sink            in_ch,
	wrfd_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t                  cfg;
	cmd_t                  cmd;
	stat_t                 stat;
	logic [ATAN_IDX_W-1:0] iter;

	// configuration registers
	wrfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer owns both handshakes
	wrfd_ctrl #(
		.ATAN_ITERATIONS (ATAN_ITERATIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.iter      (iter)
	);

	// sample path, CORDIC and gesture state
	wrfd_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.iter          (iter),
		.stat          (stat),
		.accel_x       (in_ch.accel_x),
		.accel_y       (in_ch.accel_y),
		.accel_z       (in_ch.accel_z),
		.motor_active  (in_ch.motor_active),
		.gesture_event (out_ch.gesture_event)
	);

endmodule

>>> rtl/core/wrfd_checker.sv
// ----------------------------------------------------------------------------
// wrfd_checker
// Port-level checks of the flick detector, bound to the top level.
// ----------------------------------------------------------------------------
module wrfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] gesture_event
);

	logic in_beat;

	assign in_beat = in_valid && in_ready;

	// held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(gesture_event))
		else $error("gesture changed while stalled");

	// one sample in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("sample taken while busy");

	// no result before the screen stage has run
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind wrist_roll_flick_detector_unit wrfd_checker u_wrfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.gesture_event (out_ch.gesture_event)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the wrist roll flick detector. It drives accelerometer samples
// and programs the thresholds over APB. A scoreboard predicts the gesture
// event of every accepted sample and checks each event beat against it, in
// order. Both channels idle at random, with one no-idle stretch. The event
// side holds off once for a long stretch, so the sample side backs up.
// ----------------------------------------------------------------------------
module tb
	import wrfd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SBITS       = 13;
	localparam int ROLL_STEPS  = 12;
	localparam int STALL_LIMIT = 4000;   // cycles with no beat and no APB access
	localparam int TAIL_CYCLES = 2 * (ROLL_STEPS + 5);
	localparam int HOLD_AT     = 300;    // event count that triggers the long hold-off
	localparam int HOLD_LEN    = 200;

	// atan(2^-i) in degrees, Q16
	localparam int ATAN_DEG_Q16 [16] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	// --------------------------------------------------------------------
	// Scoreboard: mirrors the thresholds and the gesture state, keeps the
	// queue of events still owed by the block.
	// --------------------------------------------------------------------
	class gesture_tracker;
		logic [LIMIT_W-1:0]  shake_lim;
		logic [LIMIT_W-1:0]  grav_lo;
		logic [LIMIT_W-1:0]  grav_hi;
		logic [ANGLE_W-1:0]  dead_zone;
		logic [ANGLE_W-1:0]  flick_thr;
		logic [ANGLE_W-1:0]  cool_len;
		logic [SETTLE_W-1:0] settle_len;

		int       ref_roll;
		bit       need_ref;
		int       settle_left;
		int       cool_left;
		gesture_t pending_gestures[$];
		int       errors;
		int       scrolls;
		int       shakes;

		function new();
			shake_lim   = SHAKE_LIMIT_RST;
			grav_lo     = GRAVITY_LOW_RST;
			grav_hi     = GRAVITY_HIGH_RST;
			dead_zone   = DEAD_ZONE_RST;
			flick_thr   = FLICK_THR_RST;
			cool_len    = COOLDOWN_RST;
			settle_len  = SETTLE_RST;
			ref_roll    = 0;
			need_ref    = 1'b1;
			settle_left = 0;
			cool_left   = 0;
			errors      = 0;
			scrolls     = 0;
			shakes      = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_SHAKE_LIMIT:  shake_lim  = v[LIMIT_W-1:0];
				REG_GRAVITY_LOW:  grav_lo    = v[LIMIT_W-1:0];
				REG_GRAVITY_HIGH: grav_hi    = v[LIMIT_W-1:0];
				REG_DEAD_ZONE:    dead_zone  = v[ANGLE_W-1:0];
				REG_FLICK_THR:    flick_thr  = v[ANGLE_W-1:0];
				REG_COOLDOWN:     cool_len   = v[ANGLE_W-1:0];
				REG_SETTLE:       settle_len = v[SETTLE_W-1:0];
				default: ;
			endcase
		endfunction

		// vectoring CORDIC on (z, y), degrees truncated toward zero
		function int roll_deg(longint y, longint z);
			longint vx, vy, acc, t;
			if (y == 0 && z == 0)
				return 0;
			vx  = z * 256;
			vy  = y * 256;
			acc = 0;
			if (vx < 0) begin
				vx  = -vx;
				vy  = -vy;
				acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
			end
			for (int i = 0; i < ROLL_STEPS; i++) begin
				t = vx;
				if (vy >= 0) begin
					vx  = vx + (vy >>> i);
					vy  = vy - (t >>> i);
					acc = acc + ATAN_DEG_Q16[i];
				end else begin
					vx  = vx - (vy >>> i);
					vy  = vy + (t >>> i);
					acc = acc - ATAN_DEG_Q16[i];
				end
			end
			t = acc / 65536;
			if (t > HALF_TURN)
				t = HALF_TURN;
			if (t < -HALF_TURN)
				t = -HALF_TURN;
			return int'(t);
		endfunction

		function void note_sample(logic signed [SBITS-1:0] ax, logic signed [SBITS-1:0] ay,
			logic signed [SBITS-1:0] az, logic motor);
			longint   sx, sy, sz, l1;
			int       roll, mag, diff;
			gesture_t ev;
			ev = EVT_NONE;
			sx = ax;
			sy = ay;
			sz = az;
			if (cool_left > 0) begin
				cool_left--;
			end else if (!motor) begin
				l1 = (sx < 0 ? -sx : sx) + (sy < 0 ? -sy : sy) + (sz < 0 ? -sz : sz);
				if (l1 > longint'(shake_lim)) begin
					cool_left   = int'(cool_len);
					need_ref    = 1'b1;
					settle_left = 0;
					ev          = EVT_SHAKE;
				end else if (l1 >= longint'(grav_lo) && l1 <= longint'(grav_hi)) begin
					roll = roll_deg(sy, sz);
					mag  = roll < 0 ? -roll : roll;
					// zero roll always passes the dead zone
					if (roll == 0 || mag >= int'(dead_zone)) begin
						if (need_ref) begin
							need_ref = 1'b0;
							ref_roll = roll;
						end else begin
							diff = roll - ref_roll;
							if (diff < -HALF_TURN)
								diff += FULL_TURN;
							if (diff > HALF_TURN)
								diff -= FULL_TURN;
							mag = diff < 0 ? -diff : diff;
							if (settle_left == 0) begin
								if (mag > int'(flick_thr))
									settle_left = (settle_len == 0) ? 1 : int'(settle_len);
								else
									ref_roll = roll;
							end else if (settle_left == 1) begin
								settle_left = 0;
								if (mag > int'(flick_thr)) begin
									ev        = (diff > 0) ? EVT_DOWN : EVT_UP;
									cool_left = int'(cool_len);
									need_ref  = 1'b1;
								end else begin
									ref_roll = roll;
								end
							end else begin
								settle_left--;
							end
						end
					end
				end
			end
			if (ev == EVT_SHAKE)
				shakes++;
			if (ev == EVT_UP || ev == EVT_DOWN)
				scrolls++;
			pending_gestures.push_back(ev);
		endfunction

		function void check_gesture(logic [1:0] got);
			gesture_t want;
			if (pending_gestures.size() == 0) begin
				errors++;
				$display("%0t: event %0d with no sample pending", $time, got);
				return;
			end
			want = pending_gestures.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: gesture_event expected %0d actual %0d", $time, want, got);
			end
		endfunction
	endclass

	// --------------------------------------------------------------------
	// Clock, reset, channels, DUT
	// --------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	wrfd_in_if #(.SAMPLE_BITS(SBITS)) in_ch ();
	wrfd_out_if                       out_ch ();

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	wrist_roll_flick_detector_unit #(
		.SAMPLE_BITS    (SBITS),
		.ATAN_ITERATIONS(ROLL_STEPS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	gesture_tracker trk;
	bit             steady;         // no idling on either side while set
	int             samples_sent;
	int             events_seen;
	int             settings_loaded;

	// --------------------------------------------------------------------
	// Event side: checks each beat, idles at random, and once holds ready
	// low for a long stretch so the DUT fills and stalls its sample input.
	// --------------------------------------------------------------------
	initial begin : event_sink
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				trk.check_gesture(out_ch.gesture_event);
				events_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (events_seen >= HOLD_AT && !held) begin
				held = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= steady || ($urandom_range(99) >= 38);
			end
		end
	end

	// watchdog: any beat or APB access resets the count
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (in_ch.valid && in_ch.ready) ||
				(out_ch.valid && out_ch.ready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// --------------------------------------------------------------------
	// Drivers. Every task is entered in the time step of a rising edge.
	// --------------------------------------------------------------------

	// setup cycle, access cycle, then an idle cycle so back-to-back
	// writes never touch psel twice in one step
	task automatic apb_write(input logic [2:0] idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		trk.write_reg(idx, PDATA_W'(value));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input int shake, input int glo, input int ghi,
		input int dz, input int flick, input int cool, input int settle);
		apb_write(REG_SHAKE_LIMIT, shake);
		apb_write(REG_GRAVITY_LOW, glo);
		apb_write(REG_GRAVITY_HIGH, ghi);
		apb_write(REG_DEAD_ZONE, dz);
		apb_write(REG_FLICK_THR, flick);
		apb_write(REG_COOLDOWN, cool);
		apb_write(REG_SETTLE, settle);
		settings_loaded++;
	endtask

	// one sample beat; valid stays high into the next beat unless an idle
	// cycle is drawn
	task automatic send_sample(input logic signed [SBITS-1:0] x,
		input logic signed [SBITS-1:0] y, input logic signed [SBITS-1:0] z,
		input logic motor);
		while (!steady && $urandom_range(99) < 38) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.accel_x      <= x;
		in_ch.accel_y      <= y;
		in_ch.accel_z      <= z;
		in_ch.motor_active <= motor;
		do
			@(posedge clk);
		while (!in_ch.ready);
		trk.note_sample(x, y, z, motor);
		samples_sent++;
	endtask

	// lower valid in the step of the last beat, then wait out every event
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (trk.pending_gestures.size() != 0)
			@(posedge clk);
	endtask

	function automatic int wrap_deg(int a);
		while (a > HALF_TURN)
			a -= FULL_TURN;
		while (a < -HALF_TURN)
			a += FULL_TURN;
		return a;
	endfunction

	// wrist at roll angle ang with L1 magnitude aimed into the gravity window
	task automatic send_pose(input int ang);
		real th, sy, cz, r;
		int  lo, hi, tgt, xa;
		lo = int'(trk.grav_lo);
		hi = int'(trk.grav_hi);
		if (hi > 3900)
			hi = 3900;
		if (lo > hi) begin
			lo = 1000;
			hi = 1700;
		end
		tgt = $urandom_range(hi, lo);
		xa  = $urandom_range(tgt / 4, 0);
		th  = ang * 3.14159265358979 / 180.0;
		sy  = $sin(th);
		cz  = $cos(th);
		r   = (tgt - xa) / ((sy < 0.0 ? -sy : sy) + (cz < 0.0 ? -cz : cz));
		send_sample(SBITS'($urandom_range(1) ? xa : -xa), SBITS'($rtoi(r * sy)),
			SBITS'($rtoi(r * cz)), 1'b0);
	endtask

	task automatic send_noise();
		logic signed [SBITS-1:0] x, y, z;
		x = SBITS'($urandom);
		y = SBITS'($urandom);
		z = SBITS'($urandom);
		send_sample(x, y, z, $urandom_range(9) == 0);
	endtask

	// one stretch of wrist motion: mostly a reference then a flick held
	// through the settling delay; sometimes broken, a shake, a motor sample or noise
	task automatic gesture_burst();
		int pick, base, d, holds, thr;
		bit broken;
		pick = $urandom_range(99);
		if (pick < 60) begin
			base = $urandom_range(360) - 180;
			repeat ($urandom_range(3, 1))
				send_pose(wrap_deg(base + $urandom_range(10) - 5));
			thr = int'(trk.flick_thr);
			d = (thr >= 179) ? 180 : thr + 1 + $urandom_range(179 - thr);
			if ($urandom_range(1))
				d = -d;
			holds  = ((trk.settle_len == 0) ? 1 : int'(trk.settle_len)) + 1;
			broken = ($urandom_range(4) == 0);
			for (int k = 0; k < holds; k++) begin
				if (broken && k == holds - 1)
					send_pose(base);
				else
					send_pose(wrap_deg(base + d + $urandom_range(4) - 2));
			end
			repeat ($urandom_range(3))
				send_noise();
		end else if (pick < 72) begin
			send_sample(
				SBITS'($urandom_range(1) ? $urandom_range(4095, 2500) : -$urandom_range(4096, 2500)),
				SBITS'($urandom_range(1) ? $urandom_range(4095, 2500) : -$urandom_range(4096, 2500)),
				SBITS'($urandom_range(1) ? $urandom_range(4095, 2500) : -$urandom_range(4096, 2500)),
				1'b0);
		end else if (pick < 82) begin
			send_sample(SBITS'($urandom), SBITS'($urandom), SBITS'($urandom), 1'b1);
		end else begin
			send_noise();
		end
	endtask

	task automatic run_phase(input int count);
		int goal;
		goal = samples_sent + count;
		while (samples_sent < goal)
			gesture_burst();
		drain();
	endtask

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------
	initial begin : main
		trk = new();
		steady = 1'b0;
		samples_sent = 0;
		events_seen = 0;
		settings_loaded = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.accel_z = '0;
		in_ch.motor_active = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset thresholds, short cooldown to save samples
		apb_write(REG_COOLDOWN, 1);
		send_sample(4000, 4000, 4000, 1'b1);    // motor running hides a shake
		send_sample(0, 0, 0, 1'b0);             // below gravity window, y=z=0
		send_sample(0, 300, 1000, 1'b0);        // roll ~17, inside dead zone
		send_sample(100, 0, 1200, 1'b0);        // zero roll, becomes reference
		repeat (3)
			send_sample(0, 1200, 0, 1'b0);      // +90: suspected, then settling
		send_sample(0, 1200, 0, 1'b0);          // check sample -> scroll down
		send_sample(-4096, -4096, -4096, 1'b0); // cooldown swallows a shake
		send_sample(0, -600, -1000, 1'b0);      // left half plane, ~-149 reference
		send_sample(0, 600, -1000, 1'b0);       // ~+149: wraps to a small step
		repeat (3)
			send_sample(0, 1000, 577, 1'b0);    // +60: inside the dead zone, ignored
		send_sample(0, 1000, 577, 1'b0);        // still inside the dead zone
		send_sample(4095, 4095, 4095, 1'b1);    // motor running hides a shake
		send_sample(0, 1200, 0, 1'b0);          // new reference +90
		send_sample(0, -1200, 0, 1'b0);         // -90: difference of half a turn
		repeat (2)
			send_sample(0, -1200, 0, 1'b0);
		send_sample(0, 1200, 0, 1'b0);          // flick gone at check: reference moves
		send_sample(-4096, -4096, -4096, 1'b0); // shake at the field minimum
		send_sample(0, 0, 0, 1'b1);             // cooldown
		send_sample(0, 1300, 0, 1'b0);          // reference re-learned after shake
		send_sample(4095, 0, 0, 1'b0);          // above gravity window
		drain();

		// reset values written back explicitly
		load_settings(SHAKE_LIMIT_RST, GRAVITY_LOW_RST, GRAVITY_HIGH_RST, DEAD_ZONE_RST,
			FLICK_THR_RST, COOLDOWN_RST, SETTLE_RST);
		run_phase(130);

		// wide open: no shake, full window, zero thresholds, settle zero
		load_settings(16383, 0, 16383, 0, 0, 0, 0);
		run_phase(130);

		// shut: nearly everything is a shake, window is a single point
		load_settings(0, 16383, 16383, 180, 180, 0, 1);
		run_phase(80);

		// no idling on either side
		steady = 1'b1;
		load_settings($urandom_range(8000, 3000), $urandom_range(1200, 700),
			$urandom_range(2600, 1300), $urandom_range(90), $urandom_range(150, 10),
			$urandom_range(15), $urandom_range(3, 1));
		run_phase(150);
		steady = 1'b0;

		// longest cooldown
		load_settings($urandom_range(8000, 3000), $urandom_range(1200, 700),
			$urandom_range(2600, 1300), $urandom_range(90), $urandom_range(120, 20),
			255, $urandom_range(3));
		run_phase(120);

		repeat (2) begin
			load_settings($urandom_range(9000, 2000), $urandom_range(1500, 0),
				$urandom_range(3500, 1200), $urandom_range(180), $urandom_range(180),
				$urandom_range(20), $urandom_range(3));
			run_phase(150);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d samples under %0d register settings, %0d events checked",
			samples_sent, settings_loaded, events_seen);
		$display("Events seen: %0d scrolls, %0d shakes", trk.scrolls, trk.shakes);
		if (trk.errors == 0 && trk.pending_gestures.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d events missing", trk.errors,
				trk.pending_gestures.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> wrist_roll_flick_detector_unit.f
rtl/core/wrfd_pkg.sv
rtl/core/wrfd_in_if.sv
rtl/core/wrfd_out_if.sv
rtl/core/wrfd_regs.sv
rtl/core/wrfd_ctrl.sv
rtl/core/wrfd_datapath.sv
rtl/core/wrist_roll_flick_detector_unit.sv
rtl/core/wrfd_checker.sv
verif/tb.sv
